/* hw/rtl/sliding_window_ack_tracker_top_assert.svh */
// Assertion macros shared by the checker files of the window tracker.
// Every macro samples on the rising edge of clk; the design must offer clk and rst_n.
`ifndef SLIDING_WINDOW_ACK_TRACKER_TOP_ASSERT_SVH
`define SLIDING_WINDOW_ACK_TRACKER_TOP_ASSERT_SVH

// This check is switched off while reset is held.
`define SWAT_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// This check stays live through reset.
`define SWAT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/swat_pkg.sv */
package swat_pkg;

  // Window geometry.
  localparam int WINDOW_SLOTS = 4;
  localparam int SLOT_W       = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int CNT_W        = $clog2(WINDOW_SLOTS + 1);

  // Field widths.
  localparam int SEQ_W       = 16;
  localparam int MSG_W       = 8;
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 3;
  localparam int OUTST_W     = 3;
  localparam int WIN_CFG_W   = 3;
  localparam int DUP_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;

  // Reset values of the configuration registers.
  localparam logic [WIN_CFG_W-1:0] WINDOW_RESET  = WIN_CFG_W'(3);
  localparam logic [DUP_W-1:0]     DUP_LIM_RESET = DUP_W'(3);

  typedef enum logic [MODE_W-1:0] {
    MODE_SEND = 2'd0,
    MODE_ACK  = 2'd1,
    MODE_TICK = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_SENT    = 3'd0,
    ST_FULL    = 3'd1,
    ST_ACKED   = 3'd2,
    ST_DUP     = 3'd3,
    ST_IGNORED = 3'd4,
    ST_RESEND  = 3'd5,
    ST_EMPTY   = 3'd6,
    ST_SPENT   = 3'd7
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW    = 2'd0,
    CFG_DUP_LIMIT = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [MSG_W-1:0]  msg_byte;
    logic [SEQ_W-1:0]  ack_seq;
    logic              ack_flag;
    logic              checksum_ok;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic               pkt_valid;
    logic [SEQ_W-1:0]   pkt_seq;
    logic [MSG_W-1:0]   pkt_msg;
    logic [SLOT_W-1:0]  slot_index;
    logic [OUTST_W-1:0] outstanding;
    logic               last;
  } result_t;

  // Effective settings after saturation.
  typedef struct packed {
    logic [CNT_W-1:0] win;
    logic [DUP_W-1:0] lim;
  } cfg_t;

endpackage

/* hw/rtl/swat_if.sv */
interface swat_in_if;
  logic                        valid;
  logic                        ready;
  logic [swat_pkg::MODE_W-1:0] mode;
  logic [swat_pkg::MSG_W-1:0]  msg_byte;
  logic [swat_pkg::SEQ_W-1:0]  ack_seq;
  logic                        ack_flag;
  logic                        checksum_ok;

  modport source (output valid, mode, msg_byte, ack_seq, ack_flag, checksum_ok,
                  input ready);
  modport sink   (input valid, mode, msg_byte, ack_seq, ack_flag, checksum_ok,
                  output ready);
  modport mon    (input valid, ready, mode, msg_byte, ack_seq, ack_flag, checksum_ok);
endinterface

interface swat_out_if;
  logic                          valid;
  logic                          ready;
  logic [swat_pkg::STATUS_W-1:0] status;
  logic                          pkt_valid;
  logic [swat_pkg::SEQ_W-1:0]    pkt_seq;
  logic [swat_pkg::MSG_W-1:0]    pkt_msg;
  logic [swat_pkg::SLOT_W-1:0]   slot_index;
  logic [swat_pkg::OUTST_W-1:0]  outstanding;
  logic                          last;

  modport source (output valid, status, pkt_valid, pkt_seq, pkt_msg, slot_index,
                  outstanding, last, input ready);
  modport sink   (input valid, status, pkt_valid, pkt_seq, pkt_msg, slot_index,
                  outstanding, last, output ready);
  modport mon    (input valid, ready, status, pkt_valid, pkt_seq, pkt_msg, slot_index,
                  outstanding, last);
endinterface

interface swat_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [swat_pkg::CFG_IDX_W-1:0]  index;
  logic [swat_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
  modport mon    (input valid, ready, index, data);
endinterface

/* hw/rtl/swat_cfg_regs.sv */
module swat_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_valid,
  output logic                            wr_ready,
  input  logic [swat_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [swat_pkg::CFG_DATA_W-1:0] wr_data,
  output swat_pkg::cfg_t                  cfg
);

  logic [swat_pkg::WIN_CFG_W-1:0] window_r;
  logic [swat_pkg::DUP_W-1:0]     dup_lim_r;

  assign wr_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= swat_pkg::WINDOW_RESET;
      dup_lim_r <= swat_pkg::DUP_LIM_RESET;
    end else if (wr_valid) begin
      unique case (wr_index)
        swat_pkg::CFG_WINDOW:    window_r  <= wr_data[swat_pkg::WIN_CFG_W-1:0];
        swat_pkg::CFG_DUP_LIMIT: dup_lim_r <= wr_data[swat_pkg::DUP_W-1:0];
        default: ;
      endcase
    end
  end

  // The window saturates into 1..WINDOW_SLOTS and a zero limit acts as one.
  always_comb begin
    if (window_r == '0) begin
      cfg.win = swat_pkg::CNT_W'(1);
    end else if (int'(window_r) > swat_pkg::WINDOW_SLOTS) begin
      cfg.win = swat_pkg::CNT_W'(swat_pkg::WINDOW_SLOTS);
    end else begin
      cfg.win = swat_pkg::CNT_W'(window_r);
    end
    cfg.lim = (dup_lim_r == '0) ? swat_pkg::DUP_W'(1) : dup_lim_r;
  end

endmodule

/* hw/rtl/swat_engine.sv */
module swat_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  swat_pkg::item_t   in_item,
  input  swat_pkg::cfg_t    cfg,
  input  logic              res_ready,
  output logic              res_valid,
  output swat_pkg::result_t res
);

  // Item register.
  logic            hold_vld_r;
  swat_pkg::item_t hold_r;

  // Window state.
  logic [swat_pkg::SEQ_W-1:0]  slot_seq_r  [swat_pkg::WINDOW_SLOTS];
  logic [swat_pkg::SEQ_W-1:0]  slot_seq_nxt[swat_pkg::WINDOW_SLOTS];
  logic [swat_pkg::MSG_W-1:0]  slot_byte_r [swat_pkg::WINDOW_SLOTS];
  logic [swat_pkg::SEQ_W-1:0]  next_seq_r, next_seq_nxt;
  logic [swat_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [swat_pkg::DUP_W-1:0]  dup_r, dup_nxt;
  logic                        rs_act_r, rs_act_nxt;
  logic [swat_pkg::SLOT_W-1:0] scan_r, scan_nxt;

  // Slot search results.
  logic [swat_pkg::WINDOW_SLOTS-1:0] held, hit;
  logic [swat_pkg::CNT_W-1:0]        hit_cnt;
  logic                              free_found, rs_found, rs_more;
  logic [swat_pkg::SLOT_W-1:0]       free_idx, rs_idx, scan_start;

  logic                       fire, done, byte_we, ack_ok, rs_go;
  logic [swat_pkg::DUP_W-1:0] dup_inc;

  assign fire      = hold_vld_r && res_ready;
  assign res_valid = fire;
  assign in_ready  = !hold_vld_r || (fire && done);

  assign ack_ok     = hold_r.ack_flag && hold_r.checksum_ok;
  assign dup_inc    = dup_r + 1'b1;
  assign scan_start = rs_act_r ? scan_r : '0;

  // Parallel compares over the slots: first free slot, ACK hits, next held slot to resend.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    hit_cnt    = '0;
    rs_found   = 1'b0;
    rs_more    = 1'b0;
    rs_idx     = '0;
    for (int i = 0; i < swat_pkg::WINDOW_SLOTS; i++) begin
      held[i] = (slot_seq_r[i] != '0);
      hit[i]  = held[i] && (slot_seq_r[i] <= hold_r.ack_seq);
      if (!held[i] && !free_found) begin
        free_found = 1'b1;
        free_idx   = swat_pkg::SLOT_W'(i);
      end
      if (hit[i]) begin
        hit_cnt = hit_cnt + swat_pkg::CNT_W'(1);
      end
      if (held[i] && (i >= int'(scan_start))) begin
        if (!rs_found) begin
          rs_found = 1'b1;
          rs_idx   = swat_pkg::SLOT_W'(i);
        end else begin
          rs_more = 1'b1;
        end
      end
    end
  end

  assign rs_go = rs_act_r ||
                 (hold_r.mode == swat_pkg::MODE_TICK) ||
                 ((hold_r.mode == swat_pkg::MODE_ACK) && ack_ok && (hit_cnt == '0) &&
                  (dup_inc >= cfg.lim));

  always_comb begin
    res            = '0;
    res.status     = swat_pkg::ST_IGNORED;
    res.last       = 1'b1;
    slot_seq_nxt   = slot_seq_r;
    next_seq_nxt   = next_seq_r;
    cnt_nxt        = cnt_r;
    dup_nxt        = dup_r;
    rs_act_nxt     = 1'b0;
    scan_nxt       = scan_r;
    byte_we        = 1'b0;
    done           = 1'b1;

    if (rs_go) begin
      // A duplicate that reaches the limit starts the count again.
      if (!rs_act_r && (hold_r.mode == swat_pkg::MODE_ACK)) begin
        dup_nxt = '0;
      end
      if (!rs_found) begin
        res.status = swat_pkg::ST_EMPTY;
      end else begin
        res.status     = swat_pkg::ST_RESEND;
        res.pkt_valid  = 1'b1;
        res.pkt_seq    = slot_seq_r[rs_idx];
        res.pkt_msg    = slot_byte_r[rs_idx];
        res.slot_index = rs_idx;
        res.last       = !rs_more;
        rs_act_nxt     = rs_more;
        scan_nxt       = rs_idx + 1'b1;
        done           = !rs_more;
      end
    end else begin
      case (hold_r.mode)
        swat_pkg::MODE_SEND: begin
          if (cnt_r >= cfg.win) begin
            res.status = swat_pkg::ST_FULL;
          end else if (next_seq_r == '0) begin
            res.status = swat_pkg::ST_SPENT;
          end else if (!free_found) begin
            res.status = swat_pkg::ST_FULL;
          end else begin
            slot_seq_nxt[free_idx] = next_seq_r;
            byte_we                = 1'b1;
            next_seq_nxt           = next_seq_r + 1'b1;
            cnt_nxt                = cnt_r + 1'b1;
            res.status             = swat_pkg::ST_SENT;
            res.pkt_valid          = 1'b1;
            res.pkt_seq            = next_seq_r;
            res.pkt_msg            = hold_r.msg_byte;
            res.slot_index         = free_idx;
          end
        end
        swat_pkg::MODE_ACK: begin
          if (!ack_ok) begin
            res.status = swat_pkg::ST_IGNORED;
          end else if (hit_cnt != '0) begin
            for (int i = 0; i < swat_pkg::WINDOW_SLOTS; i++) begin
              if (hit[i]) begin
                slot_seq_nxt[i] = '0;
              end
            end
            cnt_nxt    = (hit_cnt > cnt_r) ? '0 : cnt_r - hit_cnt;
            res.status = swat_pkg::ST_ACKED;
          end else begin
            dup_nxt    = dup_inc;
            res.status = swat_pkg::ST_DUP;
          end
        end
        default: res.status = swat_pkg::ST_IGNORED;
      endcase
    end

    res.outstanding = swat_pkg::OUTST_W'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      next_seq_r <= swat_pkg::SEQ_W'(1);
      cnt_r      <= '0;
      dup_r      <= '0;
      rs_act_r   <= 1'b0;
      scan_r     <= '0;
      for (int i = 0; i < swat_pkg::WINDOW_SLOTS; i++) begin
        slot_seq_r[i] <= '0;
      end
    end else begin
      if (in_valid && in_ready) begin
        hold_vld_r <= 1'b1;
      end else if (fire && done) begin
        hold_vld_r <= 1'b0;
      end
      if (fire) begin
        next_seq_r <= next_seq_nxt;
        cnt_r      <= cnt_nxt;
        dup_r      <= dup_nxt;
        rs_act_r   <= rs_act_nxt;
        scan_r     <= scan_nxt;
        for (int i = 0; i < swat_pkg::WINDOW_SLOTS; i++) begin
          slot_seq_r[i] <= slot_seq_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_r <= in_item;
    end
    if (fire && byte_we) begin
      slot_byte_r[free_idx] <= hold_r.msg_byte;
    end
  end

endmodule

/* hw/rtl/swat_out_stage.sv */
module swat_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  output logic              res_ready,
  input  swat_pkg::result_t res,
  output logic              out_valid,
  input  logic              out_ready,
  output swat_pkg::result_t out_res
);

  logic              out_vld_r;
  swat_pkg::result_t out_res_r;

  // A new result may enter when the register is empty or is being drained.
  assign res_ready = !out_vld_r || out_ready;
  assign out_valid = out_vld_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

endmodule

/* hw/rtl/sliding_window_ack_tracker_top.sv */
// Sender-side sliding window tracker for a go-back-N style reliable link.
// The in_ch channel takes one item per transfer: a byte to send, a received ACK,
// or a receive timeout tick, selected by the mode field.
// The out_ch channel gives one result per transfer; an item gives one result, except
// a resend (timeout tick, or the duplicate ACK that reaches the limit), which gives one
// result per held packet in slot order, or a single "nothing held" result.
// The last flag marks the final result of each item.
// The cfg_ch channel writes the window size (index 0) and the duplicate limit (index 1);
// it is always ready; the user must write it only while the block is idle, which the
// block itself does not enforce. An item is taken into the item register, and its
// results are formed from it combinationally and pass through the result register.
// The block takes one item per cycle unless the result register stalls; a resend holds
// the item register until the slot scan has emitted the last held packet.
// Reset clears the window, sets the next sequence number to one, clears both counters,
// restores both settings to three and empties the item and result registers.
// When the receiver stalls, the result register holds its contents; one more item is
// still taken into the item register, after which in_ch ready falls until results drain.
module sliding_window_ack_tracker_top (
  input logic        clk,
  input logic        rst_n,
  swat_in_if.sink    in_ch,
  swat_out_if.source out_ch,
  swat_cfg_if.sink   cfg_ch
);

  swat_pkg::cfg_t    cfg;
  swat_pkg::item_t   item;
  swat_pkg::result_t eng_res;
  swat_pkg::result_t out_res;
  logic              eng_valid;
  logic              eng_ready;
  logic              eng_in_ready;
  logic              out_valid;

  // Configuration registers with saturation of out-of-range settings.
  swat_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_ch.valid),
    .wr_ready (cfg_ch.ready),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // Gather the input fields into one item.
  assign item        = {in_ch.mode, in_ch.msg_byte, in_ch.ack_seq, in_ch.ack_flag,
                        in_ch.checksum_ok};
  assign in_ch.ready = eng_in_ready;

  // Item register, window state and the single-pass decision logic.
  swat_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (eng_in_ready),
    .in_item   (item),
    .cfg       (cfg),
    .res_ready (eng_ready),
    .res_valid (eng_valid),
    .res       (eng_res)
  );

  // Result register that separates the engine from the receiver.
  swat_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (eng_valid),
    .res_ready (eng_ready),
    .res       (eng_res),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.status      = out_res.status;
  assign out_ch.pkt_valid   = out_res.pkt_valid;
  assign out_ch.pkt_seq     = out_res.pkt_seq;
  assign out_ch.pkt_msg     = out_res.pkt_msg;
  assign out_ch.slot_index  = out_res.slot_index;
  assign out_ch.outstanding = out_res.outstanding;
  assign out_ch.last        = out_res.last;

endmodule

/* hw/rtl/swat_checker.sv */
`include "sliding_window_ack_tracker_top_assert.svh"

module swat_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [swat_pkg::STATUS_W-1:0] out_status,
  input logic                          pkt_valid,
  input logic [swat_pkg::SEQ_W-1:0]    pkt_seq,
  input logic [swat_pkg::MSG_W-1:0]    pkt_msg,
  input logic [swat_pkg::SLOT_W-1:0]   slot_index,
  input logic [swat_pkg::OUTST_W-1:0]  outstanding
);

  logic pkt_expected;
  logic pkt_fields_zero;
  logic outst_ok;

  // Only a fresh send or a resend carries a packet.
  assign pkt_expected    = (out_status == swat_pkg::ST_SENT) ||
                           (out_status == swat_pkg::ST_RESEND);
  assign pkt_fields_zero = (pkt_seq == '0) && (pkt_msg == '0) && (slot_index == '0);
  assign outst_ok        = (int'(outstanding) <= swat_pkg::WINDOW_SLOTS);

  `SWAT_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

  `SWAT_ASSERT_RUN(a_hold_valid, out_valid && !out_ready |=> out_valid, "result dropped")

  `SWAT_ASSERT_RUN(a_pkt_status, out_valid |-> (pkt_valid == pkt_expected), "bad packet flag")

  `SWAT_ASSERT_RUN(a_no_pkt_zero, out_valid && !pkt_valid |-> pkt_fields_zero, "stray fields")

  `SWAT_ASSERT_RUN(a_outst_bound, out_valid |-> outst_ok, "outstanding beyond the window")

endmodule

bind sliding_window_ack_tracker_top swat_checker u_swat_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_status  (out_ch.status),
  .pkt_valid   (out_ch.pkt_valid),
  .pkt_seq     (out_ch.pkt_seq),
  .pkt_msg     (out_ch.pkt_msg),
  .slot_index  (out_ch.slot_index),
  .outstanding (out_ch.outstanding)
);

/* tb/tb_sliding_window_ack_tracker_top.sv */
`timescale 1ns / 1ps

module tb_sliding_window_ack_tracker_top;

  // Mode 3 has no meaning to the block and must be answered as ignored.
  localparam logic [swat_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Cycles allowed after the last expected transfer before the block counts as idle.
  localparam int SETTLE_CYCLES = 8;
  // Length of the receiver hold-off that fills the block and stalls its input.
  localparam int HOLD_CYCLES   = 48;
  // Generous bound on the whole run.
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PHASE_ITEMS   = 40;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  // One line of the directed script: either an item or a register write.
  // Where typed is set, want is the single result that the item must give.
  typedef struct {
    row_kind_t                       kind;
    swat_pkg::item_t                 it;
    bit                              typed;
    swat_pkg::result_t               want;
    swat_pkg::cfg_idx_t              idx;
    logic [swat_pkg::CFG_DATA_W-1:0] data;
  } row_t;

  logic clk;
  logic rst_n;

  swat_in_if  in_ch ();
  swat_out_if out_ch ();
  swat_cfg_if cfg_ch ();

  sliding_window_ack_tracker_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Our own copy of the window: sequence numbers held per slot (zero means free),
  // their bytes, the next number to hand out, and the two counters.
  logic [swat_pkg::SEQ_W-1:0]     held_seq [swat_pkg::WINDOW_SLOTS];
  logic [swat_pkg::MSG_W-1:0]     held_byte [swat_pkg::WINDOW_SLOTS];
  logic [swat_pkg::SEQ_W-1:0]     next_seq;
  logic [swat_pkg::OUTST_W-1:0]   held_count;
  logic [swat_pkg::DUP_W-1:0]     dup_count;
  logic [swat_pkg::WIN_CFG_W-1:0] win_reg;
  logic [swat_pkg::DUP_W-1:0]     lim_reg;

  // Results produced by the item most recently accepted, and the results still owed
  // by the block, oldest first.
  swat_pkg::result_t step_results[$];
  swat_pkg::result_t pending_results[$];
  row_t              script[$];

  int mismatches;
  int send_gap_pct;
  int recv_gap_pct;
  int hold_req;

  // Free-running clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung block or a lost result ends the run here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void note_result(swat_pkg::status_t st, logic pv,
                                      logic [swat_pkg::SEQ_W-1:0] s,
                                      logic [swat_pkg::MSG_W-1:0] b,
                                      logic [swat_pkg::SLOT_W-1:0] sl);
    swat_pkg::result_t r;
    r.status      = st;
    r.pkt_valid   = pv;
    r.pkt_seq     = s;
    r.pkt_msg     = b;
    r.slot_index  = sl;
    r.outstanding = held_count;
    r.last        = 1'b0;
    step_results.push_back(r);
  endfunction

  // Every held packet goes out again in slot order; an empty window gives a single
  // result saying that nothing is held.
  function automatic void resend_held();
    for (int i = 0; i < swat_pkg::WINDOW_SLOTS; i++) begin
      if (held_seq[i] != '0) begin
        note_result(swat_pkg::ST_RESEND, 1'b1, held_seq[i], held_byte[i],
                    swat_pkg::SLOT_W'(i));
      end
    end
    if (step_results.size() == 0) begin
      note_result(swat_pkg::ST_EMPTY, 1'b0, '0, '0, '0);
    end
  endfunction

  // Applies one accepted item to the window and leaves its results in step_results.
  function automatic void advance_window(swat_pkg::item_t it);
    int unsigned       win;
    int unsigned       lim;
    int                free_slot;
    bit                cleared;
    swat_pkg::result_t tail;
    step_results.delete();
    // Out-of-range settings saturate: the window to 1..WINDOW_SLOTS, a zero limit to one.
    win = (win_reg == 0) ? 1 :
          ((win_reg > swat_pkg::WINDOW_SLOTS) ? swat_pkg::WINDOW_SLOTS : win_reg);
    lim = (lim_reg == 0) ? 1 : lim_reg;
    case (it.mode)
      swat_pkg::MODE_SEND: begin
        free_slot = -1;
        for (int i = swat_pkg::WINDOW_SLOTS - 1; i >= 0; i--) begin
          if (held_seq[i] == '0) free_slot = i;
        end
        // A full window takes precedence over a spent sequence counter.
        if (held_count >= win) begin
          note_result(swat_pkg::ST_FULL, 1'b0, '0, '0, '0);
        end else if (next_seq == '0) begin
          note_result(swat_pkg::ST_SPENT, 1'b0, '0, '0, '0);
        end else if (free_slot < 0) begin
          note_result(swat_pkg::ST_FULL, 1'b0, '0, '0, '0);
        end else begin
          held_seq[free_slot]  = next_seq;
          held_byte[free_slot] = it.msg_byte;
          held_count           = held_count + 1'b1;
          note_result(swat_pkg::ST_SENT, 1'b1, next_seq, it.msg_byte,
                      swat_pkg::SLOT_W'(free_slot));
          next_seq = next_seq + 1'b1;
        end
      end
      swat_pkg::MODE_ACK: begin
        if (!it.ack_flag || !it.checksum_ok) begin
          note_result(swat_pkg::ST_IGNORED, 1'b0, '0, '0, '0);
        end else begin
          // Cumulative: everything held at or below the acknowledged number goes.
          cleared = 1'b0;
          for (int i = 0; i < swat_pkg::WINDOW_SLOTS; i++) begin
            if (held_seq[i] != '0 && held_seq[i] <= it.ack_seq) begin
              held_seq[i] = '0;
              held_count  = held_count - 1'b1;
              cleared     = 1'b1;
            end
          end
          if (cleared) begin
            note_result(swat_pkg::ST_ACKED, 1'b0, '0, '0, '0);
          end else begin
            dup_count = dup_count + 1'b1;
            if (dup_count >= lim) begin
              dup_count = '0;
              resend_held();
            end else begin
              note_result(swat_pkg::ST_DUP, 1'b0, '0, '0, '0);
            end
          end
        end
      end
      swat_pkg::MODE_TICK: begin
        resend_held();
      end
      default: begin
        note_result(swat_pkg::ST_IGNORED, 1'b0, '0, '0, '0);
      end
    endcase
    tail = step_results.pop_back();
    tail.last = 1'b1;
    step_results.push_back(tail);
  endfunction

  // ---------------------------------------------------------------------------
  // Directed script helpers
  // ---------------------------------------------------------------------------

  function automatic row_t item_row(logic [swat_pkg::MODE_W-1:0] m,
                                    logic [swat_pkg::MSG_W-1:0] b,
                                    logic [swat_pkg::SEQ_W-1:0] a, logic f, logic ok);
    row_t r;
    r.kind  = ROW_ITEM;
    r.it    = '{mode: m, msg_byte: b, ack_seq: a, ack_flag: f, checksum_ok: ok};
    r.typed = 1'b0;
    r.want  = '0;
    r.idx   = swat_pkg::CFG_WINDOW;
    r.data  = '0;
    return r;
  endfunction

  function automatic row_t cfg_row(swat_pkg::cfg_idx_t idx,
                                   logic [swat_pkg::CFG_DATA_W-1:0] data);
    row_t r;
    r      = item_row(MODE_UNUSED, '0, '0, 1'b0, 1'b0);
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  // A typed result that carries no packet.
  function automatic row_t with_status(row_t r, swat_pkg::status_t st,
                                       logic [swat_pkg::OUTST_W-1:0] n);
    r.typed = 1'b1;
    r.want  = '{status: st, pkt_valid: 1'b0, pkt_seq: '0, pkt_msg: '0,
                slot_index: '0, outstanding: n, last: 1'b1};
    return r;
  endfunction

  // A typed result for a fresh packet going out.
  function automatic row_t with_packet(row_t r, logic [swat_pkg::SEQ_W-1:0] s,
                                       logic [swat_pkg::MSG_W-1:0] b,
                                       logic [swat_pkg::SLOT_W-1:0] sl,
                                       logic [swat_pkg::OUTST_W-1:0] n);
    r.typed = 1'b1;
    r.want  = '{status: swat_pkg::ST_SENT, pkt_valid: 1'b1, pkt_seq: s, pkt_msg: b,
                slot_index: sl, outstanding: n, last: 1'b1};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offers one item at the falling edge, with random gaps beforehand, and holds it
  // until the transfer. The expected results are then queued: the typed one where the
  // script gives it, otherwise those of the predictor, which always tracks the state.
  task automatic offer_item(swat_pkg::item_t it, bit typed, swat_pkg::result_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= it.mode;
    in_ch.msg_byte    <= it.msg_byte;
    in_ch.ack_seq     <= it.ack_seq;
    in_ch.ack_flag    <= it.ack_flag;
    in_ch.checksum_ok <= it.checksum_ok;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    advance_window(it);
    if (typed) begin
      pending_results.push_back(want);
    end else begin
      foreach (step_results[k]) pending_results.push_back(step_results[k]);
    end
  endtask

  // Stops offering, waits for every owed result and then lets the block run dry.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only once the block is idle.
  task automatic apply_setting(swat_pkg::cfg_idx_t idx,
                               logic [swat_pkg::CFG_DATA_W-1:0] data);
    settle();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == swat_pkg::CFG_WINDOW) begin
      win_reg = data[swat_pkg::WIN_CFG_W-1:0];
    end else if (idx == swat_pkg::CFG_DUP_LIMIT) begin
      lim_reg = data[swat_pkg::DUP_W-1:0];
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random traffic shaped like a real link: mostly sends and ACKs, the ACK numbers
  // aimed at what is held so that cumulative clears, partial clears and duplicates
  // all occur, with a share of invalid ACKs; ticks and the unused mode make up the rest.
  task automatic random_phase(int unsigned count);
    swat_pkg::item_t            it;
    int unsigned                pick;
    logic [swat_pkg::SEQ_W-1:0] held[$];
    repeat (count) begin
      it.msg_byte    = 8'($urandom);
      it.ack_seq     = 16'($urandom);
      it.ack_flag    = 1'($urandom);
      it.checksum_ok = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        it.mode = swat_pkg::MODE_SEND;
      end else if (pick < 85) begin
        it.mode = swat_pkg::MODE_ACK;
        held.delete();
        foreach (held_seq[i]) if (held_seq[i] != '0) held.push_back(held_seq[i]);
        case ($urandom_range(0, 3))
          0: it.ack_seq = (held.size() == 0) ? '0 : held[$urandom_range(0, held.size() - 1)];
          1: it.ack_seq = (held.size() == 0) ? '0 :
                          held[$urandom_range(0, held.size() - 1)] - 1'b1;
          2: ;
          default: it.ack_seq = next_seq - 16'($urandom_range(0, 5));
        endcase
        case ($urandom_range(0, 9))
          0: it.ack_flag = 1'b0;
          1: it.checksum_ok = 1'b0;
          default: begin
            it.ack_flag    = 1'b1;
            it.checksum_ok = 1'b1;
          end
        endcase
      end else if (pick < 95) begin
        it.mode = swat_pkg::MODE_TICK;
      end else begin
        it.mode = MODE_UNUSED;
      end
      offer_item(it, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // The receiver decides its ready at each falling edge. A hold-off request from the
  // stimulus keeps ready low for HOLD_CYCLES, counted here, whatever the gap setting.
  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
    end
  end

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // Every result transfer is matched against the oldest result still owed.
  always @(posedge clk) begin : result_check
    swat_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation waiting: status %0d", out_ch.status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("status", want.status, out_ch.status);
        compare_field("pkt_valid", want.pkt_valid, out_ch.pkt_valid);
        compare_field("pkt_seq", want.pkt_seq, out_ch.pkt_seq);
        compare_field("pkt_msg", want.pkt_msg, out_ch.pkt_msg);
        compare_field("slot_index", want.slot_index, out_ch.slot_index);
        compare_field("outstanding", want.outstanding, out_ch.outstanding);
        compare_field("last", want.last, out_ch.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = swat_pkg::MODE_SEND;
    in_ch.msg_byte    = '0;
    in_ch.ack_seq     = '0;
    in_ch.ack_flag    = 1'b0;
    in_ch.checksum_ok = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = swat_pkg::CFG_WINDOW;
    cfg_ch.data       = '0;
    mismatches        = 0;
    hold_req          = 0;
    // First the sender idles now and then while the receiver idles most of the time.
    send_gap_pct      = 31;
    recv_gap_pct      = 70;

    // The predictor starts from the reset state of the block.
    foreach (held_seq[i]) begin
      held_seq[i]  = '0;
      held_byte[i] = '0;
    end
    next_seq   = 16'd1;
    held_count = '0;
    dup_count  = '0;
    win_reg    = swat_pkg::WINDOW_RESET;
    lim_reg    = swat_pkg::DUP_LIM_RESET;

    // The directed script opens on the reset settings: a window of three, limit three.
    // A tick on an empty window, then the three ways an item is ignored.
    script.push_back(with_status(item_row(swat_pkg::MODE_TICK, 8'h00, 16'h0000, 1'b0, 1'b0),
                                 swat_pkg::ST_EMPTY, 0));
    script.push_back(with_status(item_row(swat_pkg::MODE_ACK, 8'h00, 16'h0005, 1'b0, 1'b1),
                                 swat_pkg::ST_IGNORED, 0));
    script.push_back(with_status(item_row(swat_pkg::MODE_ACK, 8'h00, 16'h0005, 1'b1, 1'b0),
                                 swat_pkg::ST_IGNORED, 0));
    script.push_back(with_status(item_row(MODE_UNUSED, 8'hFF, 16'hFFFF, 1'b1, 1'b1),
                                 swat_pkg::ST_IGNORED, 0));
    // An ACK of zero matches nothing, since zero marks a free slot.
    script.push_back(with_status(item_row(swat_pkg::MODE_ACK, 8'h00, 16'h0000, 1'b1, 1'b1),
                                 swat_pkg::ST_DUP, 0));
    // Fill the window with the extreme bytes, then one send too many.
    script.push_back(with_packet(item_row(swat_pkg::MODE_SEND, 8'h00, 16'h0000, 1'b0, 1'b0),
                                 16'd1, 8'h00, 0, 1));
    script.push_back(with_packet(item_row(swat_pkg::MODE_SEND, 8'hFF, 16'h0000, 1'b0, 1'b0),
                                 16'd2, 8'hFF, 1, 2));
    script.push_back(item_row(swat_pkg::MODE_SEND, 8'hA5, 16'h0000, 1'b0, 1'b0));
    script.push_back(with_status(item_row(swat_pkg::MODE_SEND, 8'h11, 16'h0000, 1'b0, 1'b0),
                                 swat_pkg::ST_FULL, 3));
    // A cumulative ACK frees the two lowest slots; the next send takes slot zero.
    script.push_back(item_row(swat_pkg::MODE_ACK, 8'h00, 16'h0002, 1'b1, 1'b1));
    script.push_back(item_row(swat_pkg::MODE_SEND, 8'h5A, 16'h0000, 1'b0, 1'b0));
    // A stale ACK brings the duplicate count to the limit and the window goes out again
    // in slot order; a tick does the same.
    script.push_back(item_row(swat_pkg::MODE_ACK, 8'h00, 16'h0000, 1'b1, 1'b1));
    script.push_back(item_row(swat_pkg::MODE_ACK, 8'h00, 16'h0001, 1'b1, 1'b1));
    script.push_back(item_row(swat_pkg::MODE_TICK, 8'h00, 16'h0000, 1'b0, 1'b0));
    script.push_back(with_status(item_row(swat_pkg::MODE_ACK, 8'h00, 16'hFFFF, 1'b1, 1'b1),
                                 swat_pkg::ST_ACKED, 0));
    script.push_back(with_status(item_row(swat_pkg::MODE_TICK, 8'h00, 16'h0000, 1'b0, 1'b0),
                                 swat_pkg::ST_EMPTY, 0));
    // Count three duplicates under the highest limit, then lower the limit beneath
    // the count: the next duplicate must still fire the resend.
    script.push_back(cfg_row(swat_pkg::CFG_DUP_LIMIT, 4'd15));
    repeat (3) begin
      script.push_back(with_status(item_row(swat_pkg::MODE_ACK, 8'h00, 16'h0000, 1'b1,
                                            1'b1),
                                   swat_pkg::ST_DUP, 0));
    end
    script.push_back(item_row(swat_pkg::MODE_SEND, 8'h3C, 16'h0000, 1'b0, 1'b0));
    script.push_back(cfg_row(swat_pkg::CFG_DUP_LIMIT, 4'd2));
    script.push_back(item_row(swat_pkg::MODE_ACK, 8'h00, 16'h0000, 1'b1, 1'b1));
    // A limit of zero acts as one, so every duplicate resends.
    script.push_back(cfg_row(swat_pkg::CFG_DUP_LIMIT, 4'd0));
    script.push_back(item_row(swat_pkg::MODE_ACK, 8'h00, 16'h0000, 1'b1, 1'b1));
    // A window of zero acts as one: the single held packet already fills it.
    script.push_back(cfg_row(swat_pkg::CFG_WINDOW, 4'd0));
    script.push_back(with_status(item_row(swat_pkg::MODE_SEND, 8'h80, 16'h0000, 1'b0, 1'b0),
                                 swat_pkg::ST_FULL, 1));
    script.push_back(item_row(swat_pkg::MODE_ACK, 8'h00, 16'h0005, 1'b1, 1'b1));

    // Synchronous reset, released at a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[r]) begin
      if (script[r].kind == ROW_CFG) begin
        apply_setting(script[r].idx, script[r].data);
      end else begin
        offer_item(script[r].it, script[r].typed, script[r].want);
      end
    end

    // Full window with a resend on every duplicate.
    apply_setting(swat_pkg::CFG_WINDOW, 4'd4);
    apply_setting(swat_pkg::CFG_DUP_LIMIT, 4'd1);
    random_phase(PHASE_ITEMS);

    // Gaps the other way round. The window register keeps the low three bits of the
    // written data, so this gives a window of two.
    apply_setting(swat_pkg::CFG_WINDOW, 4'hA);
    apply_setting(swat_pkg::CFG_DUP_LIMIT, 4'd15);
    send_gap_pct = 70;
    recv_gap_pct = 31;
    random_phase(PHASE_ITEMS);

    // No gaps at all, and a window setting above the slot count. At the start the
    // receiver holds off for a long stretch while items keep coming, so the block
    // fills up and stalls its input.
    apply_setting(swat_pkg::CFG_WINDOW, 4'hF);
    apply_setting(swat_pkg::CFG_DUP_LIMIT, 4'd5);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    hold_req     = hold_req + 1;
    random_phase(PHASE_ITEMS);

    // Drain everything still owed and give the block time to show any stray result.
    settle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
